// File: design/lnwt_pkg.sv
`default_nettype none
package lnwt_pkg;

	typedef enum logic [2:0] {
		MD_NAME_BYTE = 3'd0,
		MD_NAME_END  = 3'd1,
		MD_LINE_BYTE = 3'd2,
		MD_LINE_END  = 3'd3,
		MD_READ_CNT  = 3'd4,
		MD_CLEAR     = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TABLE_FULL = 3'd1,
		ST_NAME_LONG  = 3'd2,
		ST_LINE_LONG  = 3'd3,
		ST_IDX_UNUSED = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEN_RD,
		S_LEN_CK,
		S_SKIP_RD,
		S_SKIP_CK,
		S_CMP_RD,
		S_CMP_CK,
		S_FOL_CK,
		S_ADV_RD,
		S_ADV_CK,
		S_HIT_RD,
		S_HIT_WR,
		S_NEXT,
		S_FINISH,
		S_CNT_RD
	} state_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	function automatic logic [7:0] lower_byte(input logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return b >= 8'h61 && b <= 8'h7A;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

// File: design/line_name_word_tally.sv
// channel  | handshake       | words
// command  | start / busy    | mode, data_byte, name_index
// result   | done (1 cycle)  | status, name_hits, unknown_lines, total_lines,
//          |                 | line_matched, names_matched
// Byte, end-name, clear and unused modes: result in the cycle after start.
// Read count: one hit-count memory read, then the result; an unused index answers without the read.
// End line: one shared byte compare walks every name over the line; each name
// starts with a length read and check, each byte visited is a line memory read
// then a compare, each hit adds a hit-count read and write, and a finish ends.
// arst_n clears control and counters; the stores need no clearing pass.
// The receiver cannot stall; busy holds off start while a line is scanned or a
// count is read.
`default_nettype none
module line_name_word_tally #(
	parameter int MAX_NAMES = 64,
	parameter int NAME_LEN  = 32,
	parameter int LINE_LEN  = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  mode,
	input  wire logic [7:0]  data_byte,
	input  wire logic [5:0]  name_index,
	output logic             done,
	output logic [2:0]       status,
	output logic [31:0]      name_hits,
	output logic [31:0]      unknown_lines,
	output logic [31:0]      total_lines,
	output logic             line_matched,
	output logic [6:0]       names_matched
);
	import lnwt_pkg::*;

	localparam int NI_W = $clog2(MAX_NAMES + 1);
	localparam int NX_W = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
	localparam int NF_W = $clog2(NAME_LEN + 1);
	localparam int NK_W = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
	localparam int LF_W = $clog2(LINE_LEN + 1);
	localparam int LX_W = $clog2(LINE_LEN);
	localparam int IW   = $clog2(LINE_LEN + NAME_LEN + 2);
	localparam int CW   = (NI_W > 6) ? NI_W : 6;
	localparam int NM_DEPTH = MAX_NAMES << NK_W;

	logic [7:0]      line_mem [LINE_LEN];
	logic [7:0]      name_mem [NM_DEPTH];
	logic [NF_W-1:0] len_mem  [MAX_NAMES];
	logic [31:0]     hit_mem  [MAX_NAMES];

	state_t state_q, state_d;

	logic [NI_W-1:0] loaded_q;
	logic [NF_W-1:0] nfill_q;
	logic [LF_W-1:0] lfill_q;
	logic            closed_q;
	logic            colon_seen_q;
	logic [LF_W-1:0] colon_pos_q;
	logic [MAX_NAMES-1:0] hv_q;
	logic [31:0]     unknown_q, total_q;

	logic [NI_W-1:0] cur_q;
	logic [IW-1:0]   i_q;
	logic [NF_W-1:0] k_q, len_q;
	logic [7:0]      nm0_q;
	logic [6:0]      nmatch_q;
	logic            any_q;

	logic [7:0]      line_rd_q, name_rd_q;
	logic [NF_W-1:0] len_rd_q;
	logic [31:0]     hit_rd_q;

	logic            done_q, matched_q;
	logic [2:0]      status_q;
	logic [31:0]     hits_q;
	logic [6:0]      nm_out_q;

	logic [IW-1:0]   laddr;
	logic [NK_W-1:0] kaddr;
	logic [NX_W-1:0] haddr;
	logic            i_load, i_inc, k_clr, k_inc, hit_wr, cur_inc, finish, cnt_done;

	logic            accept;
	mode_t           md;
	logic [7:0]      lb, lc;
	logic [IW-1:0]   n_ext, len_ext, ik, il;
	logic [IW-1:0]   start_pos;
	logic            idx_ok;
	logic [NX_W-1:0] cur_x, load_x;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign md     = mode_t'(mode);
	assign lb     = lower_byte(data_byte);
	assign lc     = (lb == CH_TAB) ? CH_SPACE : lb;
	assign n_ext  = IW'(lfill_q);
	assign len_ext = IW'(len_q);
	assign ik     = i_q + IW'(k_q);
	assign il     = i_q + len_ext;
	assign start_pos = colon_seen_q ? IW'(colon_pos_q) : n_ext;
	assign idx_ok = CW'(name_index) < CW'(loaded_q);
	assign cur_x  = cur_q[NX_W-1:0];
	assign load_x = loaded_q[NX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		laddr    = i_q;
		kaddr    = k_q[NK_W-1:0];
		haddr    = cur_x;
		i_load   = 1'b0;
		i_inc    = 1'b0;
		k_clr    = 1'b0;
		k_inc    = 1'b0;
		hit_wr   = 1'b0;
		cur_inc  = 1'b0;
		finish   = 1'b0;
		cnt_done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				kaddr = '0;
				haddr = NX_W'(name_index);
				if (accept && md == MD_LINE_END) begin
					state_d = (loaded_q == '0) ? S_FINISH : S_LEN_RD;
				end else if (accept && md == MD_READ_CNT && idx_ok) begin
					state_d = S_CNT_RD;
				end
			end
			S_LEN_RD: begin
				kaddr   = '0;
				state_d = S_LEN_CK;
			end
			S_LEN_CK: begin
				if (len_rd_q == '0) begin
					state_d = S_NEXT;
				end else begin
					i_load  = 1'b1;
					state_d = S_SKIP_RD;
				end
			end
			S_SKIP_RD: begin
				state_d = (i_q >= n_ext) ? S_NEXT : S_SKIP_CK;
			end
			S_SKIP_CK: begin
				if (is_letter(line_rd_q) || line_rd_q == nm0_q) begin
					k_clr   = 1'b1;
					state_d = S_CMP_RD;
				end else begin
					i_inc   = 1'b1;
					state_d = S_SKIP_RD;
				end
			end
			S_CMP_RD: begin
				laddr = ik;
				if (k_q == len_q) begin
					laddr   = il;
					state_d = (il < n_ext) ? S_FOL_CK : S_HIT_RD;
				end else if (ik >= n_ext) begin
					i_inc   = 1'b1;
					state_d = S_ADV_RD;
				end else begin
					state_d = S_CMP_CK;
				end
			end
			S_CMP_CK: begin
				if (line_rd_q == name_rd_q) begin
					k_inc   = 1'b1;
					state_d = S_CMP_RD;
				end else begin
					i_inc   = 1'b1;
					state_d = S_ADV_RD;
				end
			end
			S_FOL_CK: begin
				if (is_letter(line_rd_q)) begin
					i_inc   = 1'b1;
					state_d = S_ADV_RD;
				end else begin
					state_d = S_HIT_RD;
				end
			end
			S_ADV_RD: begin
				state_d = (i_q >= n_ext) ? S_NEXT : S_ADV_CK;
			end
			S_ADV_CK: begin
				if (is_letter(line_rd_q)) begin
					i_inc   = 1'b1;
					state_d = S_ADV_RD;
				end else begin
					state_d = S_SKIP_RD;
				end
			end
			S_HIT_RD: begin
				state_d = S_HIT_WR;
			end
			S_HIT_WR: begin
				hit_wr  = 1'b1;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				if (cur_q + NI_W'(1) == loaded_q) begin
					state_d = S_FINISH;
				end else begin
					cur_inc = 1'b1;
					state_d = S_LEN_RD;
				end
			end
			S_FINISH: begin
				finish  = 1'b1;
				state_d = S_IDLE;
			end
			S_CNT_RD: begin
				cnt_done = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		line_rd_q <= line_mem[laddr[LX_W-1:0]];
		name_rd_q <= name_mem[{cur_x, kaddr}];
		len_rd_q  <= len_mem[cur_x];
		hit_rd_q  <= hit_mem[haddr];
		if (accept && md == MD_LINE_BYTE && !closed_q && data_byte != CH_CR
				&& data_byte != CH_LF && data_byte != 8'h00 && lfill_q < LF_W'(LINE_LEN)) begin
			line_mem[lfill_q[LX_W-1:0]] <= lc;
		end
		if (accept && md == MD_NAME_BYTE && loaded_q < NI_W'(MAX_NAMES)
				&& data_byte != 8'h00 && nfill_q < NF_W'(NAME_LEN)) begin
			name_mem[{load_x, nfill_q[NK_W-1:0]}] <= lb;
		end
		if (accept && md == MD_NAME_END && loaded_q < NI_W'(MAX_NAMES)) begin
			len_mem[load_x] <= nfill_q;
		end
		if (hit_wr) begin
			hit_mem[cur_x] <= sat_inc(hv_q[cur_x] ? hit_rd_q : 32'd0);
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (state_q == S_LEN_CK) begin
			len_q <= len_rd_q;
			nm0_q <= name_rd_q;
		end
		if (i_load) begin
			i_q <= start_pos;
		end else if (i_inc) begin
			i_q <= i_q + IW'(1);
		end
		if (k_clr) begin
			k_q <= '0;
		end else if (k_inc) begin
			k_q <= k_q + NF_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q     <= '0;
			nfill_q      <= '0;
			lfill_q      <= '0;
			closed_q     <= 1'b0;
			colon_seen_q <= 1'b0;
			colon_pos_q  <= '0;
			hv_q         <= '0;
			unknown_q    <= '0;
			total_q      <= '0;
			cur_q        <= '0;
			nmatch_q     <= '0;
			any_q        <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			hits_q       <= '0;
			matched_q    <= 1'b0;
			nm_out_q     <= '0;
		end else begin
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			hits_q    <= '0;
			matched_q <= 1'b0;
			nm_out_q  <= '0;
			if (accept) begin
				unique case (md)
					MD_NAME_BYTE: begin
						done_q <= 1'b1;
						if (loaded_q >= NI_W'(MAX_NAMES)) begin
							status_q <= ST_TABLE_FULL;
						end else if (data_byte == 8'h00) begin
							status_q <= ST_OK;
						end else if (nfill_q >= NF_W'(NAME_LEN)) begin
							status_q <= ST_NAME_LONG;
						end else begin
							nfill_q <= nfill_q + NF_W'(1);
						end
					end
					MD_NAME_END: begin
						done_q <= 1'b1;
						if (loaded_q >= NI_W'(MAX_NAMES)) begin
							status_q <= ST_TABLE_FULL;
						end else begin
							loaded_q <= loaded_q + NI_W'(1);
							nfill_q  <= '0;
						end
					end
					MD_LINE_BYTE: begin
						done_q <= 1'b1;
						if (!closed_q) begin
							if (data_byte == CH_CR || data_byte == CH_LF || data_byte == 8'h00) begin
								closed_q <= 1'b1;
							end else if (lfill_q >= LF_W'(LINE_LEN)) begin
								status_q <= ST_LINE_LONG;
							end else begin
								lfill_q <= lfill_q + LF_W'(1);
								if (!colon_seen_q && lc == CH_COLON) begin
									colon_seen_q <= 1'b1;
									colon_pos_q  <= lfill_q;
								end
							end
						end
					end
					MD_LINE_END: begin
						cur_q    <= '0;
						nmatch_q <= '0;
						any_q    <= 1'b0;
					end
					MD_READ_CNT: begin
						if (!idx_ok) begin
							done_q   <= 1'b1;
							status_q <= ST_IDX_UNUSED;
						end else begin
							cur_q <= NI_W'(name_index);
						end
					end
					MD_CLEAR: begin
						done_q       <= 1'b1;
						loaded_q     <= '0;
						nfill_q      <= '0;
						lfill_q      <= '0;
						closed_q     <= 1'b0;
						colon_seen_q <= 1'b0;
						hv_q         <= '0;
						unknown_q    <= '0;
						total_q      <= '0;
					end
					default: done_q <= 1'b1;
				endcase
			end
			if (cur_inc) begin
				cur_q <= cur_q + NI_W'(1);
			end
			if (hit_wr) begin
				hv_q[cur_x] <= 1'b1;
				nmatch_q    <= nmatch_q + 7'd1;
				any_q       <= 1'b1;
			end
			if (finish) begin
				done_q       <= 1'b1;
				matched_q    <= any_q;
				nm_out_q     <= nmatch_q;
				if (!any_q) begin
					unknown_q <= sat_inc(unknown_q);
				end
				total_q      <= sat_inc(total_q);
				lfill_q      <= '0;
				closed_q     <= 1'b0;
				colon_seen_q <= 1'b0;
			end
			if (cnt_done) begin
				done_q <= 1'b1;
				hits_q <= hv_q[haddr] ? hit_rd_q : 32'd0;
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign name_hits     = hits_q;
	assign unknown_lines = unknown_q;
	assign total_lines   = total_q;
	assign line_matched  = matched_q;
	assign names_matched = nm_out_q;

endmodule
`default_nettype wire
